@@ rtl/pdbe_pkg.sv @@
// Package for the principled diffuse BRDF evaluator.
// Holds configuration register indexes, reset values and fixed constants.
// No dependencies.
package pdbe_pkg;

  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 17;
  localparam int OutW = 20;

  localparam logic [CfgIdxW-1:0] CfgRoughness = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSubsurface = 2'd1;

  localparam logic [CfgDataW-1:0] RoughnessReset = 17'd32768;
  localparam logic [CfgDataW-1:0] SubsurfaceReset = 17'd0;

  localparam longint InvPiQ30 = 64'd341782638;
  localparam logic [OutW-1:0] OutMax = 20'd1048575;

endpackage

@@ rtl/pdbe_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with side payload.
// Quotient must be known to stay below 2**QB. No package dependencies.
module pdbe_div #(
  parameter int NW = 55,
  parameter int DW = 34,
  parameter int QB = 19,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QB-1:0] quot_o,
  output logic [SW-1:0] side_o
);

  localparam int CW = ((NW > DW + QB) ? NW : DW + QB) + 1;

  logic [CW-1:0] rem_q [QB];
  logic [DW-1:0] den_q [QB];
  logic [QB-1:0] quo_q [QB];
  logic [SW-1:0] sid_q [QB];
  logic [QB-1:0] vld_q;

  for (genvar i = 0; i < QB; i++) begin : g_stage
    logic [CW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QB-1:0] quo_in;
    logic [SW-1:0] sid_in;
    logic          vld_in;
    logic [CW-1:0] dsh;
    logic          ge;

    if (i == 0) begin : g_first
      assign rem_in = CW'(num_i);
      assign den_in = den_i;
      assign quo_in = '0;
      assign sid_in = side_i;
      assign vld_in = valid_i;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign den_in = den_q[i-1];
      assign quo_in = quo_q[i-1];
      assign sid_in = sid_q[i-1];
      assign vld_in = vld_q[i-1];
    end

    assign dsh = CW'(den_in) << (QB - 1 - i);
    assign ge  = (rem_in >= dsh);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[i] <= ge ? (rem_in - dsh) : rem_in;
      den_q[i] <= den_in;
      quo_q[i] <= quo_in | (QB'(ge) << (QB - 1 - i));
      sid_q[i] <= sid_in;
    end
  end

  assign valid_o = vld_q[QB-1];
  assign quot_o  = quo_q[QB-1];
  assign side_o  = sid_q[QB-1];

endmodule

@@ rtl/principled_diffuse_brdf_eval.sv @@
// Principled diffuse BRDF evaluator, top level; uses pdbe_pkg and pdbe_div.
// The result strobe follows start through front stages r1..r6, the dividers and back stages e1..e10.
// Throughput: one word per cycle, set by the fully pipelined dividers and multipliers.
// busy_o stays low; the result strobe lasts one cycle and cannot be held off.
// Reset clears valid bits and restores roughness 0.5, subsurface weight 0.
// Configuration writes are taken only while no word is in flight and start is low.
module principled_diffuse_brdf_eval #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  logic signed [15:0]                    in_dir_normal_i,
  input  logic signed [15:0]                    in_dir_tangent_i,
  input  logic signed [15:0]                    in_dir_bitangent_i,
  input  logic signed [15:0]                    out_dir_normal_i,
  input  logic signed [15:0]                    out_dir_tangent_i,
  input  logic signed [15:0]                    out_dir_bitangent_i,
  input  logic [15:0]                           base_red_i,
  input  logic [15:0]                           base_green_i,
  input  logic [15:0]                           base_blue_i,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [pdbe_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [pdbe_pkg::CfgDataW-1:0]         cfg_data_i,
  output logic                                  result_valid_o,
  output logic [pdbe_pkg::OutW-1:0]             refl_red_o,
  output logic [pdbe_pkg::OutW-1:0]             refl_green_o,
  output logic [pdbe_pkg::OutW-1:0]             refl_blue_o
);

  localparam int IW = FRAC_BITS + 10;
  localparam int QB = FRAC_BITS + 3;
  localparam int NWH = FRAC_BITS + 39;
  localparam int DWH = 34;
  localparam int NWQ = FRAC_BITS + 16;
  localparam int DWQ = 16;
  localparam int Lat = FRAC_BITS + 19;

  localparam longint OneL = longint'(1) << FRAC_BITS;
  localparam longint HalfL = longint'(1) << (FRAC_BITS - 1);
  localparam longint InvPiL =
    (pdbe_pkg::InvPiQ30 + (longint'(1) << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
  localparam longint C125L = (InvPiL * (OneL + OneL / 4) + HalfL) >> FRAC_BITS;

  localparam logic signed [IW-1:0] OneQ = IW'(OneL);
  localparam logic signed [IW-1:0] HalfQ = IW'(HalfL);
  localparam logic signed [IW-1:0] InvPiQ = IW'(InvPiL);
  localparam logic signed [IW-1:0] C125Q = IW'(C125L);

  typedef struct packed {
    logic signed [IW-1:0] cof;
    logic signed [IW-1:0] hco;
    logic signed [IW-1:0] mi;
    logic signed [IW-1:0] mo;
    logic signed [IW-1:0] pi;
    logic signed [IW-1:0] po;
    logic signed [IW-1:0] br;
    logic signed [IW-1:0] bg;
    logic signed [IW-1:0] bb;
  } side_t;

  function automatic logic signed [IW-1:0] mulq(input logic signed [IW-1:0] a,
                                                input logic signed [IW-1:0] b);
    logic signed [2*IW-1:0] p;
    logic [2*IW-1:0]        mag;
    logic [2*IW-1:0]        r;
    p   = (2*IW)'(a) * (2*IW)'(b);
    mag = p[2*IW-1] ? (2*IW)'(-p) : (2*IW)'(p);
    r   = (mag + ((2*IW)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return p[2*IW-1] ? -IW'(r) : IW'(r);
  endfunction

  function automatic logic signed [IW-1:0] to_q(input logic [16:0] x, input int src);
    logic [47:0] t;
    t = 48'(x) << (24 - src);
    if (FRAC_BITS == 24) begin
      return IW'(t);
    end
    return IW'((t + (48'(1) << (23 - FRAC_BITS))) >> (24 - FRAC_BITS));
  endfunction

  function automatic logic [pdbe_pkg::OutW-1:0] to_out(input logic signed [IW-1:0] v);
    logic [47:0] t;
    logic [47:0] r;
    t = v[IW-1] ? 48'd0 : (48'(v) << (24 - FRAC_BITS));
    r = (t + 48'd128) >> 8;
    return (r > 48'(pdbe_pkg::OutMax)) ? pdbe_pkg::OutMax : pdbe_pkg::OutW'(r);
  endfunction

  // configuration registers
  logic [pdbe_pkg::CfgDataW-1:0] rough_q;
  logic [pdbe_pkg::CfgDataW-1:0] subw_q;
  logic signed [IW-1:0]          wf;
  logic [5:0]                    inflight_q;

  assign cfg_ready_o = (inflight_q == 6'd0) && !start_i;
  assign busy_o      = 1'b0;
  assign wf          = to_q(subw_q, 16);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + 6'(start_i && !busy_o) - 6'(result_valid_o);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rough_q <= pdbe_pkg::RoughnessReset;
      subw_q  <= pdbe_pkg::SubsurfaceReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        pdbe_pkg::CfgRoughness:  rough_q <= cfg_data_i;
        pdbe_pkg::CfgSubsurface: subw_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front stages r1..r6
  logic [5:0]            rv_q;
  logic                  bk_q [6];
  side_t                 sd_q [6];
  side_t                 sd0_d, sd1_d, sd2_d, sd3_d;
  logic [15:0]           s_q  [5];
  logic [14:0]           co_q [5];
  logic signed [16:0]    hn_q, ht_q, hb_q;
  logic signed [15:0]    cor_q, ot_q, ob_q;
  logic signed [32:0]    pd_q [3];
  logic [32:0]           pn_q [3];
  logic signed [33:0]    dot_q;
  logic [33:0]           n2_q [3];
  logic [18:0]           ad15_q;
  logic [37:0]           d2_q;
  logic [NWH-1:0]        numh_q;
  logic [DWH-1:0]        denh_q;
  logic [NWQ-1:0]        numq_q;
  logic [DWQ-1:0]        denq_q;
  logic [33:0]           adot;
  logic                  bk_in;
  logic signed [16:0]    s_in;

  assign bk_in = (in_dir_normal_i <= 16'sd0) || (out_dir_normal_i <= 16'sd0);
  assign s_in  = 17'(in_dir_normal_i) + 17'(out_dir_normal_i);
  assign adot  = dot_q[33] ? 34'(-dot_q) : 34'(dot_q);

  always_comb begin
    sd0_d.cof = to_q(17'(out_dir_normal_i[14:0]), 15);
    sd0_d.hco = '0;
    sd0_d.mi  = OneQ - to_q(17'(in_dir_normal_i[14:0]), 15);
    sd0_d.mo  = OneQ - to_q(17'(out_dir_normal_i[14:0]), 15);
    sd0_d.pi  = OneQ - to_q(17'(in_dir_normal_i[14:0]), 15);
    sd0_d.po  = OneQ - to_q(17'(out_dir_normal_i[14:0]), 15);
    sd0_d.br  = to_q(17'(base_red_i), 16);
    sd0_d.bg  = to_q(17'(base_green_i), 16);
    sd0_d.bb  = to_q(17'(base_blue_i), 16);
    sd1_d     = sd_q[0];
    sd1_d.hco = mulq(sd_q[0].cof, HalfQ);
    sd1_d.pi  = mulq(sd_q[0].pi, sd_q[0].pi);
    sd1_d.po  = mulq(sd_q[0].po, sd_q[0].po);
    sd2_d     = sd_q[1];
    sd2_d.pi  = mulq(sd_q[1].pi, sd_q[1].pi);
    sd2_d.po  = mulq(sd_q[1].po, sd_q[1].po);
    sd3_d     = sd_q[2];
    sd3_d.pi  = mulq(sd_q[2].pi, sd_q[2].mi);
    sd3_d.po  = mulq(sd_q[2].po, sd_q[2].mo);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= '0;
    end else begin
      rv_q <= {rv_q[4:0], start_i && !busy_o};
    end
  end

  always_ff @(posedge clk_i) begin
    // r1
    hn_q  <= s_in;
    ht_q  <= 17'(in_dir_tangent_i) + 17'(out_dir_tangent_i);
    hb_q  <= 17'(in_dir_bitangent_i) + 17'(out_dir_bitangent_i);
    cor_q <= out_dir_normal_i;
    ot_q  <= out_dir_tangent_i;
    ob_q  <= out_dir_bitangent_i;
    s_q[0]  <= s_in[15:0];
    co_q[0] <= out_dir_normal_i[14:0];
    bk_q[0] <= bk_in;
    sd_q[0] <= sd0_d;
    sd_q[1] <= sd1_d;
    sd_q[2] <= sd2_d;
    sd_q[3] <= sd3_d;
    sd_q[4] <= sd_q[3];
    sd_q[5] <= sd_q[4];
    for (int i = 1; i < 6; i++) begin
      bk_q[i] <= bk_q[i-1];
    end
    for (int i = 1; i < 5; i++) begin
      s_q[i]  <= s_q[i-1];
      co_q[i] <= co_q[i-1];
    end
    // r2
    pd_q[0] <= 33'(hn_q) * 33'(cor_q);
    pd_q[1] <= 33'(ht_q) * 33'(ot_q);
    pd_q[2] <= 33'(hb_q) * 33'(ob_q);
    pn_q[0] <= 33'(34'(hn_q) * 34'(hn_q));
    pn_q[1] <= 33'(34'(ht_q) * 34'(ht_q));
    pn_q[2] <= 33'(34'(hb_q) * 34'(hb_q));
    // r3
    dot_q   <= 34'(pd_q[0]) + 34'(pd_q[1]) + 34'(pd_q[2]);
    n2_q[0] <= 34'(pn_q[0]) + 34'(pn_q[1]) + 34'(pn_q[2]);
    // r4
    ad15_q  <= 19'((adot + 34'd16384) >> 15);
    n2_q[1] <= n2_q[0];
    // r5
    d2_q    <= 38'(ad15_q) * 38'(ad15_q);
    n2_q[2] <= n2_q[1];
    // r6
    numh_q <= (NWH'(d2_q) << FRAC_BITS) + NWH'(n2_q[2] >> 1);
    denh_q <= n2_q[2];
    numq_q <= (NWQ'(co_q[4]) << FRAC_BITS) + NWQ'(s_q[4] >> 1);
    denq_q <= s_q[4];
  end

  // dividers
  logic          hv, qv;
  logic [QB-1:0] hw2, qq;
  side_t         dside;
  logic          dbk;

  pdbe_div #(.NW(NWH), .DW(DWH), .QB(QB), .SW($bits(side_t))) u_div_h (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rv_q[5]),
    .num_i   (numh_q),
    .den_i   (denh_q),
    .side_i  (sd_q[5]),
    .valid_o (hv),
    .quot_o  (hw2),
    .side_o  (dside)
  );

  pdbe_div #(.NW(NWQ), .DW(DWQ), .QB(QB), .SW(1)) u_div_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rv_q[5]),
    .num_i   (numq_q),
    .den_i   (denq_q),
    .side_i  (bk_q[5]),
    .valid_o (qv),
    .quot_o  (qq),
    .side_o  (dbk)
  );

  // back stages e1..e10
  logic [9:0]           pv_q;
  side_t                ps_q [9];
  logic                 pb_q [9];
  logic signed [IW-1:0] fss90_q, q_q;
  logic signed [IW-1:0] fdm1_q, fssm1_q, qmh_q;
  logic signed [IW-1:0] fdi_q, fdo_q, fsi_q, fso_q, qmh3_q;
  logic signed [IW-1:0] a_q, fss_q, fdo4_q, qmh4_q;
  logic signed [IW-1:0] b_q, in1_q;
  logic signed [IW-1:0] diff_q, sub_q;
  logic signed [IW-1:0] mixa_q, mixb_q;
  logic signed [IW-1:0] mix_q;
  logic signed [IW-1:0] vr_q, vg_q, vb_q;
  logic [pdbe_pkg::OutW-1:0] rr_q, rg_q, rb_q;
  logic [FRAC_BITS+19:0]     fprod;

  assign fprod = (FRAC_BITS+20)'(rough_q) * (FRAC_BITS+20)'(hw2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= '0;
    end else begin
      pv_q <= {pv_q[8:0], hv && qv};
    end
  end

  always_ff @(posedge clk_i) begin
    ps_q[0] <= dside;
    pb_q[0] <= dbk;
    for (int i = 1; i < 9; i++) begin
      ps_q[i] <= ps_q[i-1];
      pb_q[i] <= pb_q[i-1];
    end
    // e1
    fss90_q <= IW'((fprod + (FRAC_BITS+20)'(32768)) >> 16);
    q_q     <= IW'(qq);
    // e2
    fdm1_q  <= HalfQ + (fss90_q <<< 1) - OneQ;
    fssm1_q <= fss90_q - OneQ;
    qmh_q   <= q_q - ps_q[0].hco;
    // e3
    fdi_q  <= OneQ + mulq(fdm1_q, ps_q[1].pi);
    fdo_q  <= OneQ + mulq(fdm1_q, ps_q[1].po);
    fsi_q  <= OneQ + mulq(fssm1_q, ps_q[1].pi);
    fso_q  <= OneQ + mulq(fssm1_q, ps_q[1].po);
    qmh3_q <= qmh_q;
    // e4
    a_q    <= mulq(InvPiQ, fdi_q);
    fss_q  <= mulq(fsi_q, fso_q);
    fdo4_q <= fdo_q;
    qmh4_q <= qmh3_q;
    // e5
    b_q   <= mulq(a_q, fdo4_q);
    in1_q <= mulq(fss_q, qmh4_q) + ps_q[3].hco;
    // e6
    diff_q <= mulq(b_q, ps_q[4].cof);
    sub_q  <= mulq(C125Q, in1_q);
    // e7
    mixa_q <= mulq(diff_q, OneQ - wf);
    mixb_q <= mulq(sub_q, wf);
    // e8
    mix_q <= mixa_q + mixb_q;
    // e9
    vr_q <= mulq(ps_q[7].br, mix_q);
    vg_q <= mulq(ps_q[7].bg, mix_q);
    vb_q <= mulq(ps_q[7].bb, mix_q);
    // e10: drop back-facing words to zero
    rr_q <= pb_q[8] ? '0 : to_out(vr_q);
    rg_q <= pb_q[8] ? '0 : to_out(vg_q);
    rb_q <= pb_q[8] ? '0 : to_out(vb_q);
  end

  assign result_valid_o = pv_q[9];
  assign refl_red_o     = rr_q;
  assign refl_green_o   = rg_q;
  assign refl_blue_o    = rb_q;

`ifndef SYNTHESIS
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start_i, Lat))
    else $error("result word without a start at the pipeline latency");

  a_div_align : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hv == qv)
    else $error("divider lanes out of step");

  a_backface : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o &&
     $past(in_dir_normal_i <= 16'sd0 || out_dir_normal_i <= 16'sd0, Lat))
    |-> (refl_red_o == '0 && refl_green_o == '0 && refl_blue_o == '0))
    else $error("back-facing word gave a nonzero result");

  a_cfg_rough : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o && cfg_index_i == pdbe_pkg::CfgRoughness) |=>
    (rough_q == $past(cfg_data_i)))
    else $error("roughness write lost");
`endif

endmodule

@@ dv/principled_diffuse_brdf_eval_tb.sv @@
// Testbench for principled_diffuse_brdf_eval: directed and random direction/colour words
// checked against a fixed-point predictor of the diffuse plus subsurface BRDF.
// Depends on pdbe_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module principled_diffuse_brdf_eval_tb;

  localparam int FracBits = 16;
  localparam logic [pdbe_pkg::CfgIdxW-1:0] CfgUnused = 2'd2;
  localparam logic [pdbe_pkg::CfgIdxW-1:0] CfgSpare = 2'd3;
  localparam int DrainCycles = 45;

  typedef struct {
    logic signed [15:0] in_n, in_t, in_b, out_n, out_t, out_b;
    logic [15:0] red, green, blue;
  } shade_word_t;

  typedef struct {
    logic [pdbe_pkg::OutW-1:0] red, green, blue;
  } refl_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic signed [15:0] in_dir_normal_i = '0, in_dir_tangent_i = '0, in_dir_bitangent_i = '0;
  logic signed [15:0] out_dir_normal_i = '0, out_dir_tangent_i = '0, out_dir_bitangent_i = '0;
  logic [15:0] base_red_i = '0, base_green_i = '0, base_blue_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [pdbe_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [pdbe_pkg::CfgDataW-1:0] cfg_data_i = '0;
  logic result_valid_o;
  logic [pdbe_pkg::OutW-1:0] refl_red_o, refl_green_o, refl_blue_o;

  shade_word_t pending_words[$];
  refl_t expected_refl[$];
  logic [pdbe_pkg::CfgDataW-1:0] roughness_q = pdbe_pkg::RoughnessReset;
  logic [pdbe_pkg::CfgDataW-1:0] weight_q = pdbe_pkg::SubsurfaceReset;
  int send_idle_pct = 0;
  bit failed = 1'b0;

  principled_diffuse_brdf_eval #(.FRAC_BITS(FracBits)) dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint unsigned round_shift(longint unsigned x, int s);
    if (s == 0) return x;
    return (x + (64'd1 << (s - 1))) >> s;
  endfunction

  function automatic longint to_frac(longint unsigned x, int src);
    return longint'(round_shift(x << (24 - src), 24 - FracBits));
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    longint p;
    p = a * b;
    if (p >= 0) return (p + (64'sd1 <<< (FracBits - 1))) >>> FracBits;
    return -((-p + (64'sd1 <<< (FracBits - 1))) >>> FracBits);
  endfunction

  function automatic longint schlick5(longint f90, longint c);
    longint m, m2, m4, m5;
    m = (64'sd1 <<< FracBits) - c;
    m2 = fx_mul(m, m);
    m4 = fx_mul(m2, m2);
    m5 = fx_mul(m4, m);
    return (64'sd1 <<< FracBits) + fx_mul(f90 - (64'sd1 <<< FracBits), m5);
  endfunction

  function automatic refl_t shade_brdf(shade_word_t w);
    longint one, ci, co, ot, ob, hn, ht, hb, dotv, fss90, fd90, cif, cof, inv_pi, wf, q;
    longint diff, fss, half_co, inner, sub, mixv, v;
    longint unsigned ad, ad15, d2, n2, hw2, s15, r;
    longint unsigned base[3];
    refl_t res;
    res = '{default: '0};
    one = 64'sd1 <<< FracBits;
    ci = longint'(w.in_n);
    co = longint'(w.out_n);
    if (ci <= 0 || co <= 0) return res;
    ot = longint'(w.out_t);
    ob = longint'(w.out_b);
    hn = ci + co;
    ht = longint'(w.in_t) + ot;
    hb = longint'(w.in_b) + ob;
    dotv = hn * co + ht * ot + hb * ob;
    ad = longint'(dotv < 0 ? -dotv : dotv);
    ad15 = (ad + 16384) >> 15;
    d2 = ad15 * ad15;
    n2 = longint'(hn * hn + ht * ht + hb * hb);
    hw2 = ((d2 << FracBits) + n2 / 2) / n2;
    fss90 = longint'(round_shift(longint'(roughness_q) * hw2, 16));
    fd90 = (64'sd1 <<< (FracBits - 1)) + 2 * fss90;
    cif = to_frac(ci, 15);
    cof = to_frac(co, 15);
    inv_pi = longint'(round_shift(pdbe_pkg::InvPiQ30, 30 - FracBits));
    wf = to_frac(longint'(weight_q), 16);
    s15 = longint'(ci + co);
    q = longint'(((longint'(co) << FracBits) + s15 / 2) / s15);
    diff = fx_mul(fx_mul(fx_mul(inv_pi, schlick5(fd90, cif)), schlick5(fd90, cof)), cof);
    fss = fx_mul(schlick5(fss90, cif), schlick5(fss90, cof));
    half_co = fx_mul(cof, 64'sd1 <<< (FracBits - 1));
    inner = fx_mul(fss, q - half_co) + half_co;
    sub = fx_mul(fx_mul(inv_pi, one + one / 4), inner);
    mixv = fx_mul(diff, one - wf) + fx_mul(sub, wf);
    base[0] = longint'(w.red);
    base[1] = longint'(w.green);
    base[2] = longint'(w.blue);
    for (int k = 0; k < 3; k++) begin
      v = fx_mul(to_frac(base[k], 16), mixv);
      if (v < 0) v = 0;
      r = round_shift(longint'(v) << (24 - FracBits), 8);
      if (r > longint'(pdbe_pkg::OutMax)) r = longint'(pdbe_pkg::OutMax);
      case (k)
        0: res.red = r[pdbe_pkg::OutW-1:0];
        1: res.green = r[pdbe_pkg::OutW-1:0];
        default: res.blue = r[pdbe_pkg::OutW-1:0];
      endcase
    end
    return res;
  endfunction

  // drive the next word at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni && pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      start_i <= 1'b1;
      in_dir_normal_i <= pending_words[0].in_n;
      in_dir_tangent_i <= pending_words[0].in_t;
      in_dir_bitangent_i <= pending_words[0].in_b;
      out_dir_normal_i <= pending_words[0].out_n;
      out_dir_tangent_i <= pending_words[0].out_t;
      out_dir_bitangent_i <= pending_words[0].out_b;
      base_red_i <= pending_words[0].red;
      base_green_i <= pending_words[0].green;
      base_blue_i <= pending_words[0].blue;
    end else begin
      start_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    refl_t exp_r;
    if (rst_ni && start_i && !busy_o) begin
      expected_refl.push_back(shade_brdf(pending_words[0]));
      void'(pending_words.pop_front());
    end
    if (rst_ni && result_valid_o) begin
      if (expected_refl.size() == 0) begin
        $error("result word with none expected");
        failed = 1'b1;
      end else begin
        exp_r = expected_refl.pop_front();
        if (refl_red_o !== exp_r.red) begin
          $error("refl_red expected %0d got %0d", exp_r.red, refl_red_o);
          failed = 1'b1;
        end
        if (refl_green_o !== exp_r.green) begin
          $error("refl_green expected %0d got %0d", exp_r.green, refl_green_o);
          failed = 1'b1;
        end
        if (refl_blue_o !== exp_r.blue) begin
          $error("refl_blue expected %0d got %0d", exp_r.blue, refl_blue_o);
          failed = 1'b1;
        end
      end
    end
  end

  task automatic write_cfg(logic [pdbe_pkg::CfgIdxW-1:0] idx,
                           logic [pdbe_pkg::CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == pdbe_pkg::CfgRoughness) roughness_q = data;
    else if (idx == pdbe_pkg::CfgSubsurface) weight_q = data;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || expected_refl.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic push_word(int n, int t, int b, int on, int ot, int ob, int r, int g, int bl);
    shade_word_t w;
    w.in_n = 16'(n); w.in_t = 16'(t); w.in_b = 16'(b);
    w.out_n = 16'(on); w.out_t = 16'(ot); w.out_b = 16'(ob);
    w.red = 16'(r); w.green = 16'(g); w.blue = 16'(bl);
    pending_words.push_back(w);
  endtask

  function automatic void unit_dir(output logic signed [15:0] n, output logic signed [15:0] t,
                                   output logic signed [15:0] b);
    real rt, rb, rn;
    rt = ($urandom_range(0, 65535) / 65535.0 * 2.0 - 1.0) * 0.75;
    rb = ($urandom_range(0, 65535) / 65535.0 * 2.0 - 1.0) * 0.65;
    rn = 1.0 - rt * rt - rb * rb;
    rn = rn > 0.0 ? $sqrt(rn) : 0.0;
    n = 16'($rtoi(rn * 32767.0));
    t = 16'($rtoi(rt * 32767.0));
    b = 16'($rtoi(rb * 32767.0));
  endfunction

  task automatic push_random(int count);
    shade_word_t w;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 70) begin
        unit_dir(w.in_n, w.in_t, w.in_b);
        unit_dir(w.out_n, w.out_t, w.out_b);
        if ($urandom_range(9) == 0) w.in_n = -w.in_n;
        if ($urandom_range(9) == 0) w.out_n = -w.out_n;
      end else begin
        {w.in_n, w.in_t, w.in_b} = 48'({$urandom, $urandom});
        {w.out_n, w.out_t, w.out_b} = 48'({$urandom, $urandom});
        if ($urandom_range(1)) w.in_n[15] = 1'b0;
        if ($urandom_range(1)) w.out_n[15] = 1'b0;
      end
      {w.red, w.green} = $urandom;
      w.blue = 16'($urandom);
      if ($urandom_range(7) == 0) w.red = 16'hFFFF;
      pending_words.push_back(w);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 15;
    push_word(32767, 0, 0, 32767, 0, 0, 65535, 65535, 65535);
    push_word(32767, 0, 0, 32767, 0, 0, 0, 0, 0);
    push_word(1, 32767, 0, 1, -32768, 0, 65535, 32768, 1);
    push_word(0, 0, 0, 32767, 0, 0, 65535, 65535, 65535);
    push_word(32767, 0, 0, 0, 0, 0, 65535, 65535, 65535);
    push_word(-32768, 0, 0, 32767, 0, 0, 65535, 65535, 65535);
    push_word(32767, 0, 0, -1, 0, 0, 65535, 65535, 65535);
    push_word(32767, 32767, 32767, 32767, 32767, 32767, 65535, 65535, 65535);
    push_word(32767, -32768, -32768, 32767, 32767, 32767, 40000, 20000, 100);
    push_word(23170, 23170, 0, 23170, -23170, 0, 65535, 12345, 54321);
    push_word(1, 0, 0, 32767, 0, 0, 65535, 65535, 65535);
    push_word(32767, 0, 0, 1, 32767, 0, 65535, 65535, 65535);
    drain();

    write_cfg(pdbe_pkg::CfgRoughness, 17'd131071);
    write_cfg(pdbe_pkg::CfgSubsurface, 17'd131071);
    push_word(32767, 0, 0, 32767, 0, 0, 65535, 65535, 65535);
    push_word(1, 32767, 0, 1, -32768, 0, 65535, 65535, 65535);
    push_word(3000, 32000, 0, 3000, 0, 32000, 65535, 65535, 65535);
    drain();
    write_cfg(CfgUnused, 17'd0);
    write_cfg(CfgSpare, 17'd5);
    push_word(1, 32767, 0, 1, -32768, 0, 65535, 65535, 65535);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      send_idle_pct = phase < 2 ? 15 : (phase < 4 ? 80 : 0);
      case (phase)
        0: begin
          write_cfg(pdbe_pkg::CfgRoughness, 17'd0);
          write_cfg(pdbe_pkg::CfgSubsurface, 17'd0);
        end
        1: begin
          write_cfg(pdbe_pkg::CfgRoughness, 17'd65536);
          write_cfg(pdbe_pkg::CfgSubsurface, 17'd65536);
        end
        2: begin
          write_cfg(pdbe_pkg::CfgRoughness, 17'd131071);
          write_cfg(pdbe_pkg::CfgSubsurface, 17'd0);
        end
        3: begin
          write_cfg(pdbe_pkg::CfgRoughness, 17'd0);
          write_cfg(pdbe_pkg::CfgSubsurface, 17'd131071);
        end
        default: begin
          write_cfg(pdbe_pkg::CfgRoughness, 17'($urandom_range(0, 131071)));
          write_cfg(pdbe_pkg::CfgSubsurface, 17'($urandom_range(0, 131071)));
        end
      endcase
      push_random(125);
      drain();
    end

    if (!failed) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
